// ===== design/error_bounded_float_approximator_top_assert.svh =====
// Assertion macros used by the approximator back end (ebfa_back).
`ifndef ERROR_BOUNDED_FLOAT_APPROXIMATOR_TOP_ASSERT_SVH
`define ERROR_BOUNDED_FLOAT_APPROXIMATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define EBFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ebfa: assertion failed");

// Next-cycle implication.
`define EBFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ebfa: assertion failed");

`endif

// ===== design/ebfa_pkg.sv =====
package ebfa_pkg;

   localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAG_MASK    = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] DEFAULT_NAN = 64'hfff8_0000_0000_0000;
   localparam logic [10:0] EXP_MAX     = 11'h7ff;
   localparam int          QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        is_nan;
      logic [63:0] value_bits;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } fadd_ctl_type;

   typedef struct packed {
      logic        done;
      logic [63:0] diff;
   } fadd_res_type;

   function automatic logic is_nan(input logic [63:0] bits);
      return (bits[62:52] == EXP_MAX) && (bits[51:0] != 52'd0);
   endfunction

endpackage

// ===== design/ebfa_if.sv =====
interface ebfa_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;
   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

interface ebfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] approx_bits;
   logic        reused_previous;
   logic        fell_back;
   modport source (output valid, output approx_bits, output reused_previous,
                   output fell_back, input ready);
   modport sink (input valid, input approx_bits, input reused_previous,
                 input fell_back, output ready);
endinterface

// ===== design/ebfa_fadd.sv =====
module ebfa_fadd
   import ebfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  fadd_ctl_type ctl,
   output fadd_res_type res
);

   // stage 1: unpack, order by magnitude, detect specials
   logic        v1_ff, sp1_ff, sub1_ff, sign1_ff, zs1_ff;
   logic [63:0] spres1_ff;
   logic [55:0] big1_ff, small1_ff;
   logic [10:0] d1_ff, exp1_ff;

   logic        sa, sb, nan_a, nan_b, inf_a, inf_b, a_big, sp1_in;
   logic [63:0] spres1_in, bb;
   logic [10:0] ea, eb, exb, exs;
   logic [55:0] ma, mb;

   always_comb begin
      bb    = ctl.b ^ SIGN_BIT;
      sa    = ctl.a[63];
      sb    = bb[63];
      ea    = (ctl.a[62:52] == 11'd0) ? 11'd1 : ctl.a[62:52];
      eb    = (bb[62:52] == 11'd0) ? 11'd1 : bb[62:52];
      ma    = {ctl.a[62:52] != 11'd0, ctl.a[51:0], 3'b000};
      mb    = {bb[62:52] != 11'd0, bb[51:0], 3'b000};
      nan_a = is_nan(ctl.a);
      nan_b = is_nan(ctl.b);
      inf_a = (ctl.a[62:52] == EXP_MAX) && (ctl.a[51:0] == 52'd0);
      inf_b = (bb[62:52] == EXP_MAX) && (bb[51:0] == 52'd0);
      a_big = ctl.a[62:0] >= bb[62:0];
      exb   = a_big ? ea : eb;
      exs   = a_big ? eb : ea;
      sp1_in    = nan_a || nan_b || inf_a || inf_b;
      spres1_in = DEFAULT_NAN;
      if (nan_a) begin
         spres1_in = ctl.a | 64'h0008_0000_0000_0000;
      end else if (nan_b) begin
         spres1_in = ctl.b | 64'h0008_0000_0000_0000;
      end else if (inf_a && inf_b && (sa != sb)) begin
         spres1_in = DEFAULT_NAN;
      end else if (inf_a) begin
         spres1_in = ctl.a;
      end else if (inf_b) begin
         spres1_in = bb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.start;
      end
      sp1_ff    <= sp1_in;
      spres1_ff <= spres1_in;
      big1_ff   <= a_big ? ma : mb;
      small1_ff <= a_big ? mb : ma;
      d1_ff     <= exb - exs;
      exp1_ff   <= exb;
      sub1_ff   <= sa ^ sb;
      sign1_ff  <= a_big ? sa : sb;
      zs1_ff    <= sa & sb;
   end

   // stage 2: align the smaller operand, fold shifted-out bits into sticky
   logic        v2_ff, sp2_ff, sub2_ff, sign2_ff, zs2_ff;
   logic [63:0] spres2_ff;
   logic [55:0] big2_ff, small2_ff, small2_in, lost;
   logic [10:0] exp2_ff;

   always_comb begin
      lost = small1_ff & ((56'd1 << d1_ff[5:0]) - 56'd1);
      if (d1_ff >= 11'd56) begin
         small2_in = {55'd0, |small1_ff};
      end else begin
         small2_in = small1_ff >> d1_ff[5:0];
         small2_in[0] = small2_in[0] | (|lost);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sp2_ff    <= sp1_ff;
      spres2_ff <= spres1_ff;
      big2_ff   <= big1_ff;
      small2_ff <= small2_in;
      exp2_ff   <= exp1_ff;
      sub2_ff   <= sub1_ff;
      sign2_ff  <= sign1_ff;
      zs2_ff    <= zs1_ff;
   end

   // stage 3: add or subtract
   logic        v3_ff, sp3_ff, sign3_ff, zs3_ff;
   logic [63:0] spres3_ff;
   logic [56:0] sum3_ff;
   logic [10:0] exp3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      sp3_ff    <= sp2_ff;
      spres3_ff <= spres2_ff;
      sum3_ff   <= sub2_ff ? ({1'b0, big2_ff} - {1'b0, small2_ff})
                           : ({1'b0, big2_ff} + {1'b0, small2_ff});
      exp3_ff   <= exp2_ff;
      sign3_ff  <= sign2_ff;
      zs3_ff    <= zs2_ff;
   end

   // stage 4: leading-zero count, limited by the exponent
   logic        v4_ff, sp4_ff, sign4_ff;
   logic [63:0] spres4_ff;
   logic [56:0] sum4_ff;
   logic [11:0] exp4_ff, exp_m1;
   logic [5:0]  sh4_ff, lz, sh_in;

   always_comb begin
      lz = 6'd56;
      for (int i = 0; i < 56; i++) begin
         if (sum3_ff[i]) begin
            lz = 6'(55 - i);
         end
      end
      exp_m1 = {1'b0, exp3_ff} - 12'd1;
      sh_in  = ({6'd0, lz} <= exp_m1) ? lz : exp_m1[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      sp4_ff    <= sp3_ff;
      spres4_ff <= spres3_ff;
      sum4_ff   <= sum3_ff;
      exp4_ff   <= {1'b0, exp3_ff};
      sh4_ff    <= sh_in;
      sign4_ff  <= (sum3_ff == 57'd0) ? zs3_ff : sign3_ff;
   end

   // stage 5: normalise
   logic        v5_ff, sp5_ff, sign5_ff;
   logic [63:0] spres5_ff;
   logic [55:0] m5_ff;
   logic [11:0] exp5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      sp5_ff    <= sp4_ff;
      spres5_ff <= spres4_ff;
      sign5_ff  <= sign4_ff;
      if (sum4_ff[56]) begin
         m5_ff   <= {sum4_ff[56:2], sum4_ff[1] | sum4_ff[0]};
         exp5_ff <= exp4_ff + 12'd1;
      end else begin
         m5_ff   <= sum4_ff[55:0] << sh4_ff;
         exp5_ff <= exp4_ff - {6'd0, sh4_ff};
      end
   end

   // stage 6: round to nearest even and pack
   logic        v6_ff, up;
   logic [63:0] out6_ff, out6_in;
   logic [10:0] ef;
   logic [62:0] packed_mag;

   always_comb begin
      up         = m5_ff[2] & (m5_ff[1] | m5_ff[0] | m5_ff[3]);
      ef         = m5_ff[55] ? exp5_ff[10:0] : 11'd0;
      packed_mag = {ef, m5_ff[54:3]} + {62'd0, up};
      if (sp5_ff) begin
         out6_in = spres5_ff;
      end else if (exp5_ff >= {1'b0, EXP_MAX}) begin
         out6_in = {sign5_ff, EXP_MAX, 52'd0};
      end else begin
         out6_in = {sign5_ff, packed_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      out6_ff <= out6_in;
   end

   assign res.done = v6_ff;
   assign res.diff = out6_ff;

endmodule

// ===== design/ebfa_front.sv =====
module ebfa_front
   import ebfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ebfa_req_if.sink   req,
   input  logic       pop,
   output head_type   head
);

   entry_type   entry_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff;
   logic        push;

   assign req.ready  = cnt_ff != 2'(QUEUE_DEPTH);
   assign push       = req.valid && req.ready;
   assign head.valid = cnt_ff != 2'd0;
   assign head.entry = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{is_nan: is_nan(req.value_bits),
                                  value_bits: req.value_bits};
      end
   end

endmodule

// ===== design/ebfa_back.sv =====
module ebfa_back
   import ebfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  head_type     head,
   output logic         pop,
   input  logic         csr_we,
   input  logic [62:0]  csr_wdata,
   output fadd_ctl_type fadd_ctl,
   input  fadd_res_type fadd_res,
   ebfa_rsp_if.source   rsp
);

`include "error_bounded_float_approximator_top_assert.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_REUSE, ST_LO, ST_HI, ST_LZ, ST_STEP, ST_TRY1, ST_WAIT1, ST_TRY2,
      ST_WAIT2
   } state_type;

   state_type    state_ff;
   fadd_ctl_type ctl_ff;
   logic         out_valid_ff, reused_ff, fell_ff, nan_ff, sign_ff;
   logic [63:0]  approx_ff, prev_ff, v_ff, lo_ff, lo_b_ff, hi_b_ff;
   logic [63:0]  front_ff, rear_ff, c1_ff, c2_ff;
   logic [62:0]  max_error_ff;
   logic [5:0]   s_ff;

   logic [63:0]  e_bits, sgn, bit_s, rear_in, front_in, lob, hib, hi;
   logic         close, lo_ge0, hi_le0, in_range1, in_range2, issue, waiting;

   always_comb begin
      e_bits = {1'b0, max_error_ff};
      close  = !is_nan(fadd_res.diff) && !is_nan(e_bits) &&
               (fadd_res.diff[62:0] <= max_error_ff);
      sgn    = sign_ff ? SIGN_BIT : 64'd0;
      hi     = fadd_res.diff;
      lo_ge0 = !is_nan(lo_ff) && (!lo_ff[63] || lo_ff[62:0] == 63'd0);
      hi_le0 = !is_nan(hi) && (hi[63] || hi[62:0] == 63'd0);
      if (lo_ge0) begin
         lob = lo_ff;
         hib = hi;
      end else if (hi_le0) begin
         lob = hi ^ SIGN_BIT;
         hib = lo_ff ^ SIGN_BIT;
      end else if (!prev_ff[63]) begin
         lob = 64'd0;
         hib = hi;
      end else begin
         lob = 64'd0;
         hib = lo_ff ^ SIGN_BIT;
      end
      bit_s     = 64'd1 << s_ff;
      rear_in   = rear_ff & ~bit_s;
      front_in  = front_ff | (lo_b_ff & bit_s);
      in_range1 = ($signed(c1_ff) >= $signed(lo_b_ff)) &&
                  ($signed(c1_ff) <= $signed(hi_b_ff));
      in_range2 = $signed(c2_ff) <= $signed(hi_b_ff);
      issue     = pop ||
                  (fadd_res.done && ((state_ff == ST_LO) ||
                                     ((state_ff == ST_REUSE) && !close && !nan_ff))) ||
                  ((state_ff == ST_TRY1) && in_range1) ||
                  ((state_ff == ST_TRY2) && in_range2);
      waiting   = (state_ff == ST_REUSE) || (state_ff == ST_LO) || (state_ff == ST_HI) ||
                  (state_ff == ST_WAIT1) || (state_ff == ST_WAIT2);
   end

   assign pop                 = (state_ff == ST_IDLE) && head.valid && !out_valid_ff;
   assign fadd_ctl            = ctl_ff;
   assign rsp.valid           = out_valid_ff;
   assign rsp.approx_bits     = approx_ff;
   assign rsp.reused_previous = reused_ff;
   assign rsp.fell_back       = fell_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         ctl_ff.start <= 1'b0;
         prev_ff      <= 64'd0;
         max_error_ff <= 63'd0;
      end else begin
         ctl_ff.start <= issue;
         if (csr_we) begin
            max_error_ff <= csr_wdata;
         end
         if (out_valid_ff && rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  v_ff         <= head.entry.value_bits;
                  nan_ff       <= head.entry.is_nan;
                  ctl_ff.a     <= prev_ff;
                  ctl_ff.b     <= head.entry.value_bits;
                  state_ff     <= ST_REUSE;
               end
            end
            ST_REUSE: begin
               if (fadd_res.done) begin
                  if (close) begin
                     out_valid_ff <= 1'b1;
                     approx_ff    <= prev_ff;
                     reused_ff    <= 1'b1;
                     fell_ff      <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else if (nan_ff) begin
                     out_valid_ff <= 1'b1;
                     approx_ff    <= v_ff;
                     prev_ff      <= v_ff;
                     reused_ff    <= 1'b0;
                     fell_ff      <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     ctl_ff.a     <= v_ff;
                     ctl_ff.b     <= e_bits;
                     state_ff     <= ST_LO;
                  end
               end
            end
            ST_LO: begin
               if (fadd_res.done) begin
                  lo_ff        <= fadd_res.diff;
                  ctl_ff.a     <= v_ff;
                  ctl_ff.b     <= e_bits ^ SIGN_BIT;
                  state_ff     <= ST_HI;
               end
            end
            ST_HI: begin
               if (fadd_res.done) begin
                  lo_b_ff <= lob & MAG_MASK;
                  hi_b_ff <= hib;
                  sign_ff <= !lo_ge0 && (hi_le0 || prev_ff[63]);
                  s_ff    <= 6'd63;
                  if (((lob & MAG_MASK) ^ hib) == 64'd0) begin
                     out_valid_ff <= 1'b1;
                     approx_ff    <= v_ff;
                     prev_ff      <= v_ff;
                     reused_ff    <= 1'b0;
                     fell_ff      <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_LZ;
                  end
               end
            end
            ST_LZ: begin
               if ((lo_b_ff[s_ff] ^ hi_b_ff[s_ff]) != 1'b0) begin
                  front_ff <= lo_b_ff & ~((64'd2 << s_ff) - 64'd1);
                  rear_ff  <= prev_ff & ((64'd2 << s_ff) - 64'd1);
                  state_ff <= ST_STEP;
               end else begin
                  s_ff <= s_ff - 6'd1;
               end
            end
            ST_STEP: begin
               rear_ff  <= rear_in;
               front_ff <= front_in;
               c1_ff    <= rear_in + front_in;
               c2_ff    <= (rear_in + front_in + bit_s) & MAG_MASK;
               state_ff <= ST_TRY1;
            end
            ST_TRY1: begin
               if (in_range1) begin
                  ctl_ff.a     <= c1_ff ^ sgn;
                  ctl_ff.b     <= v_ff;
                  state_ff     <= ST_WAIT1;
               end else begin
                  state_ff <= ST_TRY2;
               end
            end
            ST_WAIT1: begin
               if (fadd_res.done) begin
                  if (close) begin
                     out_valid_ff <= 1'b1;
                     approx_ff    <= c1_ff ^ sgn;
                     prev_ff      <= c1_ff ^ sgn;
                     reused_ff    <= 1'b0;
                     fell_ff      <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_TRY2;
                  end
               end
            end
            ST_TRY2: begin
               if (in_range2) begin
                  ctl_ff.a     <= c2_ff ^ sgn;
                  ctl_ff.b     <= v_ff;
                  state_ff     <= ST_WAIT2;
               end else if (s_ff == 6'd0) begin
                  out_valid_ff <= 1'b1;
                  approx_ff    <= v_ff;
                  prev_ff      <= v_ff;
                  reused_ff    <= 1'b0;
                  fell_ff      <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  s_ff     <= s_ff - 6'd1;
                  state_ff <= ST_STEP;
               end
            end
            ST_WAIT2: begin
               if (fadd_res.done) begin
                  if (close) begin
                     out_valid_ff <= 1'b1;
                     approx_ff    <= c2_ff ^ sgn;
                     prev_ff      <= c2_ff ^ sgn;
                     reused_ff    <= 1'b0;
                     fell_ff      <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else if (s_ff == 6'd0) begin
                     out_valid_ff <= 1'b1;
                     approx_ff    <= v_ff;
                     prev_ff      <= v_ff;
                     reused_ff    <= 1'b0;
                     fell_ff      <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     s_ff     <= s_ff - 6'd1;
                     state_ff <= ST_STEP;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `EBFA_ASSERT_IMPL(a_flags_excl, clock, reset, out_valid_ff, !(reused_ff && fell_ff))
   `EBFA_ASSERT_IMPL(a_done_waiting, clock, reset, fadd_res.done, waiting)
   `EBFA_ASSERT_IMPL(a_busy_no_out, clock, reset, state_ff != ST_IDLE, !out_valid_ff)
   `EBFA_ASSERT_NEXT(a_pop_issue, clock, reset, pop, ctl_ff.start)

endmodule

// ===== design/error_bounded_float_approximator_top.sv =====
// Error-bounded double approximator. Each request carries one IEEE 754 double;
// each response returns a pattern within the absolute error held in the csr
// register, preferring bits shared with the previous response. Requests queue
// two deep ahead of a sequencer that owns one six-stage double subtractor and
// issues one subtraction at a time. A request first tests whether the previous
// pattern can be reused, then subtracts to get the interval bounds, skips the
// leading bits that the bounds share and, per scanned bit position, tests up
// to two candidates with one subtraction each.
module error_bounded_float_approximator_top
   import ebfa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ebfa_req_if.sink      req_chan,
   ebfa_rsp_if.source    rsp_chan,
   input  logic          csr_we,
   input  logic [62:0]   csr_wdata
);

   head_type     head;
   logic         pop;
   fadd_ctl_type fadd_ctl;
   fadd_res_type fadd_res;

   ebfa_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head)
   );

   ebfa_fadd u_fadd (
      .clock (clock),
      .reset (reset),
      .ctl   (fadd_ctl),
      .res   (fadd_res)
   );

   ebfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fadd_ctl  (fadd_ctl),
      .fadd_res  (fadd_res),
      .rsp       (rsp_chan)
   );

endmodule

// ===== bench/tb_error_bounded_float_approximator_top.sv =====
`timescale 1ns / 100ps

module tb_error_bounded_float_approximator_top;
   import ebfa_pkg::*;

   localparam int IDLE_LIMIT = 6000;
   localparam int PER_SETTING = 140;

   typedef struct {
      logic [63:0] approx_bits;
      logic        reused_previous;
      logic        fell_back;
   } rsp_fields_type;

   typedef struct {
      logic [63:0]    value_bits;
      logic           typed;
      rsp_fields_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [62:0] csr_wdata = '0;

   ebfa_req_if req_chan ();
   ebfa_rsp_if rsp_chan ();

   error_bounded_float_approximator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   logic [63:0] last_pattern = '0;
   logic [63:0] error_bound = '0;
   rsp_fields_type pending_rsp[$];
   stim_row_type   typed_rows[$];
   int fails = 0;
   int requests = 0;
   int responses = 0;
   int reuse_seen = 0;
   int fallback_seen = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;
   int rsp_hold = 0;

   function automatic logic within_bound(logic [63:0] cand, real orig, real e);
      real d;
      d = $bitstoreal(cand) - orig;
      return $bitstoreal($realtobits(d) & MAG_MASK) <= e;
   endfunction

   function automatic logic search_interval(real lo, real hi, logic [63:0] sgn, real orig,
                                            logic [63:0] prior, real e,
                                            output logic [63:0] found);
      logic [63:0] lo_b, hi_b, diff, fmask, front, rear, bitm, c;
      logic signed [63:0] lo_s, hi_s;
      int lz;
      lo_b = $realtobits(lo) & MAG_MASK;
      hi_b = $realtobits(hi);
      lo_s = lo_b;
      hi_s = hi_b;
      diff = lo_b ^ hi_b;
      found = '0;
      lz = 0;
      while (lz < 64 && diff[63 - lz] == 1'b0) lz++;
      if (lz == 64) return 1'b0;
      fmask = (lz == 0) ? 64'd0 : (ALL_ONES << (64 - lz));
      front = fmask & lo_b;
      rear = ~fmask & prior;
      for (int s = 63 - lz; s >= 0; s--) begin
         bitm = 64'd1 << s;
         rear &= ~bitm;
         front |= lo_b & bitm;
         c = rear + front;
         if ($signed(c) >= lo_s && $signed(c) <= hi_s) begin
            if (within_bound(c ^ sgn, orig, e)) begin
               found = c ^ sgn;
               return 1'b1;
            end
         end
         c = (rear + front + bitm) & MAG_MASK;
         if ($signed(c) <= hi_s) begin
            if (within_bound(c ^ sgn, orig, e)) begin
               found = c ^ sgn;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_fields_type approximate(logic [63:0] vb);
      rsp_fields_type r;
      real v, e, lo, hi;
      logic [63:0] pick;
      logic ok;
      v = $bitstoreal(vb);
      e = $bitstoreal(error_bound);
      r.reused_previous = 1'b0;
      r.fell_back = 1'b0;
      pick = '0;
      if (within_bound(last_pattern, v, e)) begin
         r.reused_previous = 1'b1;
      end else if (vb[62:52] == EXP_MAX && vb[51:0] != 52'd0) begin
         last_pattern = vb;
      end else begin
         lo = v - e;
         hi = v + e;
         if (lo >= 0.0) ok = search_interval(lo, hi, 64'd0, v, last_pattern, e, pick);
         else if (hi <= 0.0)
            ok = search_interval(-hi, -lo, SIGN_BIT, v, last_pattern, e, pick);
         else if (last_pattern[63] == 1'b0)
            ok = search_interval(0.0, hi, 64'd0, v, last_pattern, e, pick);
         else ok = search_interval(0.0, -lo, SIGN_BIT, v, last_pattern, e, pick);
         if (!ok) begin
            pick = vb;
            r.fell_back = 1'b1;
         end
         last_pattern = pick;
      end
      r.approx_bits = last_pattern;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_fields_type got, want, pred;
      stim_row_type row;
      if (!reset && req_chan.valid && req_chan.ready) begin
         row = typed_rows.pop_front();
         pred = approximate(req_chan.value_bits);
         pending_rsp = {pending_rsp, (row.typed ? row.want : pred)};
         requests++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.approx_bits = rsp_chan.approx_bits;
         got.reused_previous = rsp_chan.reused_previous;
         got.fell_back = rsp_chan.fell_back;
         responses++;
         reuse_seen += got.reused_previous;
         fallback_seen += got.fell_back;
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding: approx_bits %h", got.approx_bits);
            fails++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.approx_bits !== want.approx_bits) begin
               $error("approx_bits: expected %h, got %h", want.approx_bits, got.approx_bits);
               fails++;
            end
            if (got.reused_previous !== want.reused_previous) begin
               $error("reused_previous: expected %b, got %b", want.reused_previous,
                      got.reused_previous);
               fails++;
            end
            if (got.fell_back !== want.fell_back) begin
               $error("fell_back: expected %b, got %b", want.fell_back, got.fell_back);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_chan.ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 18);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_request(logic [63:0] vb, logic typed, rsp_fields_type want);
      stim_row_type row;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      row.value_bits = vb;
      row.typed = typed;
      row.want = want;
      typed_rows = {typed_rows, row};
      req_chan.valid <= 1'b1;
      req_chan.value_bits <= vb;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_error_bound(logic [63:0] eb);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending_rsp.size() == 0);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= eb[62:0];
      @(posedge clock);
      error_bound = eb & MAG_MASK;
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] random_value(logic [63:0] prior);
      logic [63:0] v;
      int k;
      case ($urandom_range(0, 9))
         0: v = {$urandom, $urandom};
         1: begin
            case ($urandom_range(0, 7))
               0: v = 64'h0000_0000_0000_0000;
               1: v = 64'h8000_0000_0000_0000;
               2: v = 64'h7ff0_0000_0000_0000;
               3: v = 64'hfff0_0000_0000_0000;
               4: v = {1'($urandom_range(0, 1)), EXP_MAX, 21'h0,
                       31'($urandom_range(1, 2**31 - 1))};
               5: v = 64'h7fef_ffff_ffff_ffff;
               6: v = 64'h0000_0000_0000_0001;
               default: v = 64'hffff_ffff_ffff_ffff;
            endcase
         end
         2, 3: v = {1'($urandom_range(0, 1)), 11'($urandom_range(1008, 1032)),
                    20'($urandom), 32'($urandom)};
         default: begin
            k = $urandom_range(0, 52);
            v = prior ^ ({$urandom, $urandom} & ((64'd1 << k) - 64'd1));
            if ($urandom_range(0, 9) == 0) v[63] = ~v[63];
         end
      endcase
      return v;
   endfunction

   logic [63:0] error_settings[9] = '{
      64'h3f50_624d_d2f1_a9fc, 64'h3ff0_0000_0000_0000, 64'h0000_0000_0000_0001,
      64'h7fef_ffff_ffff_ffff, 64'h7ff0_0000_0000_0000, 64'h7ff8_0000_0000_0000,
      64'h3eb0_c6f7_a0b5_ed8d, 64'h4120_0000_0000_0000, 64'h0000_0000_0000_0000
   };

   stim_row_type directed[12] = '{
      '{64'h0000_0000_0000_0000, 1'b1, '{64'h0000_0000_0000_0000, 1'b1, 1'b0}},
      '{64'h7ff8_0000_0000_0001, 1'b1, '{64'h7ff8_0000_0000_0001, 1'b0, 1'b0}},
      '{64'h7ff0_0000_0000_0000, 1'b1, '{64'h7ff0_0000_0000_0000, 1'b0, 1'b1}},
      '{64'h3ff0_0000_0000_0000, 1'b1, '{64'h3ff0_0000_0000_0000, 1'b0, 1'b1}},
      '{64'h3ff0_0000_0000_0000, 1'b1, '{64'h3ff0_0000_0000_0000, 1'b1, 1'b0}},
      '{64'hbff0_0000_0000_0000, 1'b1, '{64'hbff0_0000_0000_0000, 1'b0, 1'b1}},
      '{64'h8000_0000_0000_0000, 1'b0, '{64'h0, 1'b0, 1'b0}},
      '{64'hffff_ffff_ffff_ffff, 1'b0, '{64'h0, 1'b0, 1'b0}},
      '{64'h7fef_ffff_ffff_ffff, 1'b0, '{64'h0, 1'b0, 1'b0}},
      '{64'h0000_0000_0000_0001, 1'b0, '{64'h0, 1'b0, 1'b0}},
      '{64'hfff0_0000_0000_0000, 1'b0, '{64'h0, 1'b0, 1'b0}},
      '{64'h5555_aaaa_3333_cccc, 1'b0, '{64'h0, 1'b0, 1'b0}}
   };

   initial begin
      logic [63:0] prior;
      req_chan.valid = 1'b0;
      req_chan.value_bits = '0;
      rsp_chan.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_request(directed[i].value_bits, directed[i].typed, directed[i].want);
      write_error_bound(64'h3ff0_0000_0000_0000);
      foreach (directed[i]) send_request(directed[i].value_bits, 1'b0, directed[i].want);
      prior = 64'h3ff0_0000_0000_0000;
      foreach (error_settings[p]) begin
         write_error_bound(error_settings[p]);
         calm = (p == 8);
         repeat (PER_SETTING) begin
            prior = random_value(prior);
            send_request(prior, 1'b0, directed[0].want);
         end
      end
      req_chan.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (40) @(posedge clock);
      $display("covered %0d requests and %0d responses over %0d error bounds",
               requests, responses, 11);
      $display("reuse taken %0d times, search fallback %0d times", reuse_seen, fallback_seen);
      if (fails == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
